>>> rtl/core/htsd_pkg.sv
// shared types and constants of the huffman table stream decoder
package htsd_pkg;

	localparam int unsigned TREE_DEPTH_DEF = 512;
	localparam int unsigned CMDQ_DEPTH_DEF = 2;
	localparam int unsigned OUTQ_DEPTH_DEF = 4;

	// status codes of a result
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_MAGIC = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_TRUNC = 2'd3;

	typedef struct packed {
		logic [7:0] stream_byte;
		logic       stream_end;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       out_last;
		logic [1:0] status;
	} result_t;

	// one command from front to back, built from one accepted byte
	typedef struct packed {
		logic        start;
		logic [23:0] size;
		logic        nib_mode;
		logic [9:0]  tree_bytes;
		logic        walk;
		logic [31:0] word;
		logic        fin;
		logic        partial;
		logic        st_valid;
		logic [1:0]  st;
	} cmd_t;

	typedef struct packed {
		logic       en;
		logic [9:0] addr;
		logic [7:0] data;
	} tree_wr_t;

endpackage

>>> rtl/core/htsd_fifo.sv
// small register queue used between front and back and at the result side
module htsd_fifo
	import htsd_pkg::*;
#(
	parameter type T = cmd_t,
	parameter int unsigned DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  T     wdata,
	output logic full,
	input  logic rd,
	output T     rdata,
	output logic empty
);
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	T              store_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = store_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full)
			store_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr && !full)
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (rd && !empty)
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			case ({wr && !full, rd && !empty})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |=> (cnt_q == CW'(DEPTH)) || $past(rd))
		else $error("queue count dropped without a read");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue count beyond depth");
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> (wp_q == rp_q))
		else $error("empty queue with unequal pointers");

endmodule

>>> rtl/core/htsd_front.sv
// header parsing, tree loading and code word assembly
module htsd_front
	import htsd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     take,
	input  item_t    item,
	output logic     tree_phase,
	output logic     cmd_wr,
	output cmd_t     cmd,
	output tree_wr_t tree_wr
);
	typedef enum logic [2:0] {
		PH_MAGIC, PH_SIZE, PH_TLEN, PH_TREE, PH_DATA, PH_DONE
	} phase_t;

	phase_t      phase_q, phase_nx;
	logic        nib_q;
	logic [23:0] size_q;
	logic [1:0]  hcnt_q;
	logic [9:0]  tb_q, fill_q, fill_inc;
	logic [23:0] wacc_q;
	logic [1:0]  wfill_q;
	logic [7:0]  b;

	assign b          = item.stream_byte;
	assign tree_phase = (phase_q == PH_TREE);
	assign fill_inc   = fill_q + 1'b1;

	always_comb begin
		cmd      = '0;
		phase_nx = phase_q;
		cmd.size       = size_q;
		cmd.nib_mode   = nib_q;
		cmd.tree_bytes = tb_q;
		cmd.word       = {b, wacc_q};
		tree_wr.en   = 1'b0;
		tree_wr.addr = fill_inc;
		tree_wr.data = b;
		unique case (phase_q)
			PH_MAGIC: begin
				if (b[7:4] != 4'h2) begin
					cmd.st_valid = 1'b1;
					cmd.st       = ST_MAGIC;
					phase_nx     = PH_DONE;
				end else begin
					phase_nx = PH_SIZE;
				end
			end
			PH_SIZE:
				if (hcnt_q == 2'd2)
					phase_nx = PH_TLEN;
			PH_TLEN:  phase_nx = PH_TREE;
			PH_TREE: begin
				// only an accepted byte goes into the table
				tree_wr.en = take;
				if (fill_inc >= tb_q) begin
					if (size_q == '0) begin
						cmd.st_valid = 1'b1;
						cmd.st       = ST_OK;
						phase_nx     = PH_DONE;
					end else begin
						cmd.start = 1'b1;
						phase_nx  = PH_DATA;
					end
				end
			end
			PH_DATA:  cmd.walk = (wfill_q == 2'd3);
			PH_DONE:  ;
			default:  phase_nx = PH_MAGIC;
		endcase
		if (item.stream_end) begin
			if (phase_nx == PH_DATA) begin
				cmd.fin     = 1'b1;
				cmd.partial = (phase_q == PH_DATA) && (wfill_q != 2'd3);
			end else if (phase_nx != PH_DONE) begin
				cmd.st_valid = 1'b1;
				cmd.st       = ST_TRUNC;
			end
		end
	end

	assign cmd_wr = take && (cmd.start || cmd.walk || cmd.fin || cmd.st_valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC;
			nib_q   <= 1'b0;
			size_q  <= '0;
			hcnt_q  <= '0;
			tb_q    <= '0;
			fill_q  <= '0;
			wacc_q  <= '0;
			wfill_q <= '0;
		end else if (take) begin
			if (item.stream_end) begin
				phase_q <= PH_MAGIC;
				nib_q   <= 1'b0;
				size_q  <= '0;
				hcnt_q  <= '0;
				tb_q    <= '0;
				fill_q  <= '0;
				wacc_q  <= '0;
				wfill_q <= '0;
			end else begin
				phase_q <= phase_nx;
				case (phase_q)
					PH_MAGIC: begin
						nib_q  <= (b[3:0] == 4'h4);
						size_q <= '0;
						hcnt_q <= '0;
					end
					PH_SIZE: begin
						case (hcnt_q)
							2'd0:    size_q[7:0]   <= b;
							2'd1:    size_q[15:8]  <= b;
							default: size_q[23:16] <= b;
						endcase
						if (hcnt_q != 2'd2)
							hcnt_q <= hcnt_q + 1'b1;
					end
					PH_TLEN: begin
						tb_q   <= {1'b0, b, 1'b1};
						fill_q <= '0;
					end
					PH_TREE: begin
						fill_q  <= fill_inc;
						wacc_q  <= '0;
						wfill_q <= '0;
					end
					PH_DATA: begin
						case (wfill_q)
							2'd0:    wacc_q[7:0]   <= b;
							2'd1:    wacc_q[15:8]  <= b;
							2'd2:    wacc_q[23:16] <= b;
							default: wacc_q        <= '0;
						endcase
						wfill_q <= wfill_q + 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

endmodule

>>> rtl/core/htsd_back.sv
// tree table and walker: one node read per code bit
module htsd_back
	import htsd_pkg::*;
#(
	parameter int unsigned TREE_DEPTH = TREE_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  tree_wr_t tree_wr,
	input  cmd_t     qcmd,
	input  logic     qempty,
	output logic     qpop,
	output logic     busy,
	output logic     res_wr,
	output result_t  res,
	input  logic     res_full
);
	localparam int unsigned AW = $clog2(TREE_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE, S_CHK, S_BIT, S_NODE, S_LEAF, S_FLUSH, S_TAIL, S_STAT
	} state_t;

	state_t      state_q;
	cmd_t        cmd_q;
	logic        active_q, nib_q, pend_q;
	logic [23:0] size_q, bytes_q, bytes_inc;
	logic [9:0]  tb_q, node_q;
	logic [4:0]  bit_q;
	logic [3:0]  hi_q;
	logic [7:0]  mem [TREE_DEPTH];
	logic [7:0]  rd_q, t;
	logic [AW-1:0] rd_addr;
	logic        bitv, leaf, oor, hit, emit_leaf, go;
	logic [10:0] child;

	assign t         = rd_q;
	assign bitv      = cmd_q.word[bit_q];
	assign child     = {1'b0, node_q[9:1], 1'b0} + {4'd0, t[5:0], 1'b0} + 11'd2
		+ {10'd0, bitv};
	assign leaf      = bitv ? t[6] : t[7];
	assign oor       = child > {1'b0, tb_q};
	assign bytes_inc = bytes_q + 1'b1;
	assign hit       = (bytes_inc == size_q);
	assign emit_leaf = !nib_q || pend_q;
	assign rd_addr   = (state_q == S_NODE) ? child[AW-1:0] : node_q[AW-1:0];
	assign busy      = (state_q != S_IDLE);
	assign qpop      = (state_q == S_IDLE) && !qempty;

	always_ff @(posedge clk) begin
		if (tree_wr.en)
			mem[tree_wr.addr[AW-1:0]] <= tree_wr.data;
		// read data held while the result side stalls
		if (state_q == S_BIT || (state_q == S_NODE && go))
			rd_q <= mem[rd_addr];
	end

	always_comb begin
		res_wr = 1'b0;
		res    = '0;
		case (state_q)
			S_NODE:
				if (oor) begin
					res_wr   = 1'b1;
					res      = '{8'd0, 1'b0, 1'b1, ST_RANGE};
				end
			S_LEAF:
				if (emit_leaf) begin
					res_wr = 1'b1;
					res    = '{nib_q ? {hi_q, t[3:0]} : t, 1'b1, hit, ST_OK};
				end
			S_FLUSH: begin
				res_wr = 1'b1;
				res    = '{{hi_q, 4'd0}, 1'b1, hit, ST_OK};
			end
			S_TAIL: begin
				res_wr = 1'b1;
				res    = '{8'd0, 1'b0, 1'b1, ST_TRUNC};
			end
			S_STAT: begin
				res_wr = 1'b1;
				res    = '{8'd0, 1'b0, 1'b1, cmd_q.st};
			end
			default: ;
		endcase
		go = !res_wr || !res_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cmd_q    <= '0;
			active_q <= 1'b0;
			nib_q    <= 1'b0;
			pend_q   <= 1'b0;
			size_q   <= '0;
			bytes_q  <= '0;
			tb_q     <= '0;
			node_q   <= 10'd1;
			bit_q    <= '0;
			hi_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE:
					if (!qempty) begin
						cmd_q <= qcmd;
						bit_q <= 5'd31;
						if (qcmd.start) begin
							active_q <= 1'b1;
							size_q   <= qcmd.size;
							nib_q    <= qcmd.nib_mode;
							tb_q     <= qcmd.tree_bytes;
							node_q   <= 10'd1;
							bytes_q  <= '0;
							pend_q   <= 1'b0;
							hi_q     <= '0;
						end
						state_q <= (qcmd.walk && (qcmd.start || active_q)) ? S_BIT : S_CHK;
					end
				S_CHK: begin
					if (cmd_q.fin)
						active_q <= 1'b0;
					if (cmd_q.fin && active_q)
						state_q <= (!cmd_q.partial && node_q == 10'd1 && pend_q)
							? S_FLUSH : S_TAIL;
					else if (cmd_q.st_valid)
						state_q <= S_STAT;
					else
						state_q <= S_IDLE;
				end
				S_BIT: state_q <= S_NODE;
				S_NODE:
					if (go) begin
						if (oor) begin
							active_q <= 1'b0;
							state_q  <= S_CHK;
						end else if (!leaf) begin
							node_q <= child[9:0];
							if (bit_q == '0)
								state_q <= S_CHK;
							else
								bit_q <= bit_q - 1'b1;
						end else begin
							node_q  <= 10'd1;
							state_q <= S_LEAF;
						end
					end
				S_LEAF:
					if (go) begin
						if (nib_q) begin
							pend_q <= !pend_q;
							if (!pend_q)
								hi_q <= t[3:0];
						end
						if (emit_leaf) begin
							bytes_q <= bytes_inc;
							if (hit)
								active_q <= 1'b0;
						end
						if ((emit_leaf && hit) || bit_q == '0) begin
							state_q <= S_CHK;
						end else begin
							bit_q   <= bit_q - 1'b1;
							state_q <= S_BIT;
						end
					end
				S_FLUSH:
					if (go) begin
						pend_q  <= 1'b0;
						bytes_q <= bytes_inc;
						state_q <= hit ? S_IDLE : S_TAIL;
					end
				S_TAIL, S_STAT:
					if (go)
						state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_wr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		tree_wr.en |-> (state_q == S_IDLE) && qempty)
		else $error("tree written while walker busy");
	a_range_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_NODE && oor && go) |=> !active_q && state_q == S_CHK)
		else $error("walk goes on after a range fault");
	a_last_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(res_wr && !res_full && res.out_valid && res.out_last) |=> !active_q)
		else $error("walker active after final byte");

endmodule

>>> rtl/core/huffman_table_stream_decoder.sv
// top level of the huffman table stream decoder
// Takes a compressed stream one byte per transaction (header, tree table, then
// 32-bit little-endian code words) and delivers decompressed bytes and status
// results through a result queue. The front parses each accepted byte and
// hands a command to a two-entry queue; the back walks each code word one bit
// at a time through the tree memory: a bit that reaches an internal node is
// handled in S_NODE alone, a bit that ends in a leaf also passes S_LEAF, and
// the next bit restarts at the root in S_BIT. Each 32-bit word's command is
// fetched in S_IDLE and closed in S_CHK. A byte is one symbol, or two in the
// 4-bit mode. Tree bytes are held off (full high) until the back has drained,
// since they overwrite the table the walker reads. The tree memory is not
// cleared by reset; it is written by each stream before use.
module huffman_table_stream_decoder
	import htsd_pkg::*;
#(
	parameter int unsigned TREE_DEPTH = TREE_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  item_t   item,
	output logic    full,
	input  logic    pop,
	output result_t result,
	output logic    empty
);
	cmd_t     fcmd, qcmd;
	tree_wr_t tree_wr;
	result_t  bres;
	logic     tree_phase, cmd_wr, cq_full, cq_empty, qpop, busy, res_wr, rq_full;
	logic     take;

	// tree bytes wait for an empty command queue and an idle walker
	assign full = cq_full || (tree_phase && (!cq_empty || busy));
	assign take = push && !full;

	htsd_front u_front (
		.clk, .arst_n, .take, .item, .tree_phase, .cmd_wr,
		.cmd(fcmd), .tree_wr
	);

	// command queue between front and back
	htsd_fifo #(.T(cmd_t), .DEPTH(CMDQ_DEPTH_DEF)) u_cmdq (
		.clk, .arst_n, .wr(cmd_wr), .wdata(fcmd), .full(cq_full),
		.rd(qpop), .rdata(qcmd), .empty(cq_empty)
	);

	htsd_back #(.TREE_DEPTH(TREE_DEPTH)) u_back (
		.clk, .arst_n, .tree_wr, .qcmd, .qempty(cq_empty), .qpop, .busy,
		.res_wr, .res(bres), .res_full(rq_full)
	);

	// result queue, oldest result shown while not empty
	htsd_fifo #(.T(result_t), .DEPTH(OUTQ_DEPTH_DEF)) u_resq (
		.clk, .arst_n, .wr(res_wr), .wdata(bres), .full(rq_full),
		.rd(pop), .rdata(result), .empty
	);

endmodule
